[src/fys_pkg.sv]
// Shared types and constants for the shuffle engine.
`timescale 1ns / 1ps

package fys_pkg;

    localparam int CMD_W        = 2;
    localparam int INDEX_W      = 6;
    localparam int IN_VALUE_W   = 4;
    localparam int OUT_VALUE_W  = 4;
    localparam int WORD_W       = 31;
    localparam int CURSOR_W     = 6;
    localparam int LEN_W        = 7;
    localparam int REM_W        = 6;
    localparam int DIVISOR_W    = 7;
    localparam int STEP_CNT_W   = 5;
    localparam int CURSOR_LIMIT = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE   = 2'd0,
        CMD_RESTART = 2'd1,
        CMD_STEP    = 2'd2,
        CMD_READ    = 2'd3
    } fys_cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ_WAIT,
        S_DIVIDE,
        S_READ_J,
        S_SWAP_J,
        S_DONE
    } fys_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } fys_mod_status_t;

endpackage

[src/fys_mod_unit.sv]
// Restoring bit-serial remainder unit: random word mod (cursor + 1).
`timescale 1ns / 1ps

module fys_mod_unit
    import fys_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WORD_W-1:0]    dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output fys_mod_status_t      status,
    output logic [REM_W-1:0]     remainder
);

    localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(WORD_W - 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic [WORD_W-1:0]     shift_reg, shift_next;
    logic [DIVISOR_W-1:0]  divisor_reg, divisor_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  trial;
    logic [DIVISOR_W-1:0]  diff;

    // remainder stays below the divisor (at most 64), so one bit more covers the trial
    assign trial = {rem_reg, shift_reg[WORD_W-1]};
    assign diff  = trial - divisor_reg;

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        shift_next   = shift_reg;
        divisor_next = divisor_reg;
        rem_next     = rem_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            cnt_next     = '0;
            shift_next   = dividend;
            divisor_next = divisor;
            rem_next     = '0;
        end
        else if (busy_reg)
        begin
            shift_next = {shift_reg[WORD_W-2:0], 1'b0};
            rem_next   = (trial >= divisor_reg) ? diff[REM_W-1:0] : trial[REM_W-1:0];
            cnt_next   = cnt_reg + STEP_CNT_W'(1);
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg   <= shift_next;
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign remainder   = rem_reg;

endmodule

[src/fisher_yates_shuffle_engine.sv]
// Top level: symbol table memory, shuffle sequencer and result register.
// Sequence per item: write, restart or finished step go straight from idle to done, read
// passes through read wait, shuffle step through divide (the one-bit-per-cycle remainder
// unit), read partner and swap. One item at a time: the next item is taken in the cycle
// after the result is loaded, so a swap step's throughput is bounded by the remainder loop.
// Reset clears the cursor and sets the length to 64 (capped by MAX_ENTRIES);
// table contents are undefined until written.
`timescale 1ns / 1ps

module fisher_yates_shuffle_engine
    import fys_pkg::*;
#(
    parameter int MAX_ENTRIES = 64,
    parameter int VALUE_BITS  = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   config_write,
    input  logic [LEN_W-1:0]       config_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [CMD_W-1:0]       command,
    input  logic [INDEX_W-1:0]     index,
    input  logic [IN_VALUE_W-1:0]  value,
    input  logic [WORD_W-1:0]      random_word,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [OUT_VALUE_W-1:0] read_value,
    output logic [CURSOR_W-1:0]    cursor_position,
    output logic [CURSOR_W-1:0]    swap_partner,
    output logic                   shuffle_done
);

    // entries above the cursor range can never be addressed
    localparam int STORE_DEPTH = (MAX_ENTRIES < CURSOR_LIMIT) ? MAX_ENTRIES : CURSOR_LIMIT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(STORE_DEPTH);

    fys_state_t state_reg, state_next;

    logic [CURSOR_W-1:0]    cursor_reg, cursor_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic                   out_valid_reg, out_valid_next;

    logic                   in_range_reg;
    logic [OUT_VALUE_W-1:0] res_read_reg;
    logic [CURSOR_W-1:0]    res_partner_reg;
    logic [VALUE_BITS-1:0]  tmp_reg;
    logic [OUT_VALUE_W-1:0] read_value_reg;
    logic [CURSOR_W-1:0]    cursor_position_reg;
    logic [CURSOR_W-1:0]    swap_partner_reg;
    logic                   shuffle_done_reg;

    logic [VALUE_BITS-1:0]  store_mem [STORE_DEPTH];
    logic [VALUE_BITS-1:0]  rdata_reg;

    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [VALUE_BITS-1:0]  mem_wdata;
    logic                   mem_re;
    logic [ADDR_W-1:0]      mem_raddr;

    logic                   accept;
    logic                   in_range;
    logic                   cursor_zero;
    logic                   out_load;
    logic                   mod_start;
    fys_cmd_t               cmd;
    fys_mod_status_t        mod_status;
    logic [REM_W-1:0]       mod_rem;
    logic [DIVISOR_W-1:0]   divisor;

    logic [VALUE_BITS+IN_VALUE_W-1:0]  wr_ext;
    logic [VALUE_BITS+OUT_VALUE_W-1:0] rd_ext;

    assign cmd         = fys_cmd_t'(command);
    assign accept      = in_valid && !in_stall;
    assign in_range    = {1'b0, index} < len_reg;
    assign cursor_zero = (cursor_reg == '0);
    assign divisor     = {1'b0, cursor_reg} + DIVISOR_W'(1);
    assign wr_ext      = {{VALUE_BITS{1'b0}}, value};
    assign rd_ext      = {{OUT_VALUE_W{1'b0}}, rdata_reg};

    fys_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (random_word),
        .divisor   (divisor),
        .status    (mod_status),
        .remainder (mod_rem)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == CMD_READ)
                        state_next = S_READ_WAIT;
                    else if (cmd == CMD_STEP && !cursor_zero)
                        state_next = S_DIVIDE;
                    else
                        state_next = S_DONE;
                end
            end
            S_READ_WAIT: state_next = S_DONE;
            S_DIVIDE:
            begin
                if (mod_status.done)
                    state_next = S_READ_J;
            end
            S_READ_J:    state_next = S_SWAP_J;
            S_SWAP_J:    state_next = S_DONE;
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_stall  = 1'b1;
        mem_we    = 1'b0;
        mem_waddr = cursor_reg[ADDR_W-1:0];
        mem_wdata = rdata_reg;
        mem_re    = 1'b0;
        mem_raddr = cursor_reg[ADDR_W-1:0];
        mod_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    unique case (cmd)
                        CMD_WRITE:
                        begin
                            mem_we    = in_range;
                            mem_waddr = index[ADDR_W-1:0];
                            mem_wdata = wr_ext[VALUE_BITS-1:0];
                        end
                        CMD_READ:
                        begin
                            mem_re    = 1'b1;
                            mem_raddr = index[ADDR_W-1:0];
                        end
                        CMD_STEP:
                        begin
                            mem_re    = !cursor_zero;
                            mod_start = !cursor_zero;
                        end
                        CMD_RESTART: ;
                        default: ;
                    endcase
                end
            end
            S_READ_WAIT: ;
            S_DIVIDE:
            begin
                // entry at the cursor sits in rdata; fetch the partner
                if (mod_status.done)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = mod_rem[ADDR_W-1:0];
                end
            end
            S_READ_J:
            begin
                mem_we    = 1'b1;
                mem_waddr = cursor_reg[ADDR_W-1:0];
                mem_wdata = rdata_reg;
            end
            S_SWAP_J:
            begin
                mem_we    = 1'b1;
                mem_waddr = res_partner_reg[ADDR_W-1:0];
                mem_wdata = tmp_reg;
            end
            S_DONE:
            begin
                out_load = !out_valid_reg || !out_stall;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        cursor_next    = cursor_reg;
        len_next       = len_reg;
        out_valid_next = out_valid_reg;
        if (config_write)
        begin
            if (config_data == '0)
                len_next = LEN_W'(1);
            else if (config_data > LEN_CAP)
                len_next = LEN_CAP;
            else
                len_next = config_data;
        end
        if (accept && cmd == CMD_RESTART)
            cursor_next = CURSOR_W'(len_reg - LEN_W'(1));
        else if (state_reg == S_SWAP_J)
            cursor_next = cursor_reg - CURSOR_W'(1);
        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cursor_reg    <= '0;
            len_reg       <= LEN_CAP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath and result registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_range_reg    <= in_range;
            res_read_reg    <= '0;
            res_partner_reg <= '0;
        end
        if (state_reg == S_READ_WAIT)
            res_read_reg <= in_range_reg ? rd_ext[OUT_VALUE_W-1:0] : '0;
        if (state_reg == S_DIVIDE && mod_status.done)
        begin
            tmp_reg         <= rdata_reg;
            res_partner_reg <= mod_rem;
        end
        if (out_load)
        begin
            read_value_reg      <= res_read_reg;
            cursor_position_reg <= cursor_reg;
            swap_partner_reg    <= res_partner_reg;
            shuffle_done_reg    <= cursor_zero;
        end
    end

    // symbol table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= store_mem[mem_raddr];
    end

    assign out_valid       = out_valid_reg;
    assign read_value      = read_value_reg;
    assign cursor_position = cursor_position_reg;
    assign swap_partner    = swap_partner_reg;
    assign shuffle_done    = shuffle_done_reg;

    // remainder unit only finishes while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        mod_status.done |-> state_reg == S_DIVIDE)
        else $error("remainder done outside divide state");

    // remainder unit only runs inside the divide state
    assert property (@(posedge clk) disable iff (!rst_n)
        mod_status.busy |-> state_reg == S_DIVIDE)
        else $error("remainder busy outside divide state");

    // swap partner never lies above the cursor
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ_J |-> res_partner_reg <= cursor_reg)
        else $error("swap partner above cursor");

    // a completed swap moves the cursor down by exactly one
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SWAP_J |=> cursor_reg == CURSOR_W'($past(cursor_reg) - CURSOR_W'(1)))
        else $error("cursor not decremented after swap");

    // second write of a swap always follows the first
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SWAP_J |-> $past(state_reg) == S_READ_J)
        else $error("swap write without partner read");

endmodule
